// File: hdl/cra_pkg.sv
// ----------------------------------------------------------------------------
// cra_pkg
// Types and codes shared by the contiguous ring allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cra_pkg;

  localparam int CAP_W = 17;  // capacity, sizes and free counts
  localparam int POS_W = 18;  // unwrapped tail position
  localparam int OFS_W = 16;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 17'd65536;

  typedef struct packed {
    logic [1:0]       func;
    logic [CAP_W-1:0] size;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [OFS_W-1:0] offset;
    logic [CAP_W-1:0] free_total;
    logic [CAP_W-1:0] free_contiguous;
  } rsp_t;

  typedef struct packed {
    logic [CAP_W-1:0] head_pos;
    logic [POS_W-1:0] tail_pos;
    logic [CAP_W-1:0] ring_end;
  } ring_state_t;

endpackage

`default_nettype wire

// File: hdl/cra_step.sv
// ----------------------------------------------------------------------------
// cra_step
// Next ring state and result for one request, combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module cra_step (
  input  cra_pkg::req_t        req,
  input  cra_pkg::ring_state_t st,
  input  logic [16:0]          eff_cap,
  output cra_pkg::ring_state_t st_next,
  output cra_pkg::rsp_t        rsp
);
  import cra_pkg::*;

  logic [POS_W-1:0] h, t, e, sz, cap;
  logic [POS_W-1:0] nh, nt, ne, hs, ofs;
  logic [POS_W-1:0] over, gap;
  logic             wrapped, ok;
  logic [POS_W-1:0] top, over_n, v;
  logic [POS_W:0]   tot, run;

  always_comb begin
    h       = {1'b0, st.head_pos};
    t       = st.tail_pos;
    e       = {1'b0, st.ring_end};
    sz      = {1'b0, req.size};
    cap     = {1'b0, eff_cap};
    nh      = h;
    nt      = t;
    ne      = e;
    hs      = h + sz;
    ofs     = '0;
    ok      = 1'b0;
    wrapped = (t >= e);
    over    = t - e;
    gap     = e - t;
    case (req.func)
      FUNC_ALLOC: begin
        if (!wrapped) begin
          if (gap >= sz) begin
            ok  = 1'b1;
            ofs = t;
            nt  = t + sz;
          end else if (h != t) begin
            // lower the ring end to the tail and try the gap below the head
            ne = t;
            if (sz <= h) begin
              ok = 1'b1;
              nt = t + sz;
            end
          end
        end else if (h >= over && (h - over) >= sz) begin
          ok  = 1'b1;
          ofs = over;
          nt  = t + sz;
        end
      end
      FUNC_RELEASE: begin
        if ((t - h) >= sz) begin
          ok = 1'b1;
          if (hs == t) begin
            nh = '0;
            nt = '0;
            ne = cap;
          end else if (hs >= e) begin
            // head has crossed the ring end: unwrap
            nh = hs - e;
            nt = t - e;
            ne = cap;
          end else begin
            nh = hs;
          end
        end
      end
      FUNC_CLEAR: begin
        ok = 1'b1;
        nh = '0;
        nt = '0;
        ne = cap;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    top    = (cap > nt) ? cap - nt : '0;
    over_n = nt - ne;
    v      = (nh > over_n) ? nh - over_n : '0;
    if (nt < ne) begin
      tot = {1'b0, top} + {1'b0, nh};
      run = (top > nh) ? {1'b0, top} : {1'b0, nh};
    end else begin
      tot = {1'b0, v};
      run = {1'b0, v};
    end
  end

  assign st_next.head_pos    = nh[CAP_W-1:0];
  assign st_next.tail_pos    = nt;
  assign st_next.ring_end    = ne[CAP_W-1:0];
  assign rsp.status          = ~ok;
  assign rsp.offset          = ok ? ofs[OFS_W-1:0] : '0;
  assign rsp.free_total      = tot[CAP_W-1:0];
  assign rsp.free_contiguous = run[CAP_W-1:0];

endmodule

`default_nettype wire

// File: hdl/contiguous_ring_allocator_core.sv
// ----------------------------------------------------------------------------
// contiguous_ring_allocator_core
// Ring allocator handing out contiguous blocks, released in FIFO order.
// ----------------------------------------------------------------------------
// A request is taken in every cycle (busy stays low); it is registered in the
// request register, then passes through the update logic into the result
// register and the ring state, where its result appears with done. done lasts a
// single cycle and cannot be held off. cfg_ready is always high; a capacity
// write empties the ring and may only be issued while no request is in
// flight. The usable capacity is the written value limited to 2^ADDR_BITS.
`default_nettype none

module contiguous_ring_allocator_core #(
  parameter int ADDR_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cra_pkg::req_t req,
  output logic          done,
  output cra_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [16:0]   cfg_data
);
  import cra_pkg::*;

  localparam logic [POS_W-1:0] CAP_LIM =
    (ADDR_BITS >= CAP_W) ? POS_W'(1 << CAP_W) : POS_W'(1 << ADDR_BITS);

  function automatic logic [CAP_W-1:0] limit_cap(input logic [CAP_W-1:0] c);
    logic [POS_W-1:0] cx;
    cx = {1'b0, c};
    limit_cap = (cx < CAP_LIM) ? c : CAP_LIM[CAP_W-1:0];
  endfunction

  logic [CAP_W-1:0] capacity;
  ring_state_t      ring;
  ring_state_t      ring_next;
  logic             req_valid;
  req_t             req_q;
  rsp_t             rsp_next;
  logic             cfg_write;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  cra_step u_step (
    .req     (req_q),
    .st      (ring),
    .eff_cap (limit_cap(capacity)),
    .st_next (ring_next),
    .rsp     (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start & ~busy;
    end
    req_q <= req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_RESET;
      ring.head_pos <= '0;
      ring.tail_pos <= '0;
      ring.ring_end <= limit_cap(CAP_RESET);
      done          <= 1'b0;
    end else begin
      done <= req_valid;
      if (cfg_write) begin
        capacity      <= cfg_data;
        ring.head_pos <= '0;
        ring.tail_pos <= '0;
        ring.ring_end <= limit_cap(cfg_data);
      end else if (req_valid) begin
        ring <= ring_next;
      end
    end
    if (req_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/cra_checker.sv
// ----------------------------------------------------------------------------
// cra_checker
// Port-level checks for the contiguous ring allocator, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module cra_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input cra_pkg::rsp_t rsp
);

  // every accepted transaction gives a result on done
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted transaction gave no result");

  a_done_caused: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy, 2) && !$past(rst, 2) && !$past(rst, 1)))
    else $error("result without a transaction");

  a_fail_offset: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status) |-> (rsp.offset == '0))
    else $error("failed transaction reports an offset");

  a_run_le_total: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.free_contiguous <= rsp.free_total))
    else $error("contiguous free run exceeds total free space");

endmodule

bind contiguous_ring_allocator_core cra_checker u_cra_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire
